>>> design/acpu_pkg.sv
// shared types, constants and codes for the accumulator cpu core
package acpu_pkg;

  localparam int MEM_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int WORD_W    = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  // input commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // result events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PRINT   = 3'd1;
  localparam logic [2:0] EV_SLEEP   = 3'd2;
  localparam logic [2:0] EV_SHELL   = 3'd3;
  localparam logic [2:0] EV_HALTED  = 3'd4;
  localparam logic [2:0] EV_IGNORED = 3'd5;

  // opcodes, compared against the whole fetched word
  localparam logic [WORD_W-1:0] OP_HALT  = WORD_W'(0);
  localparam logic [WORD_W-1:0] OP_LDI   = WORD_W'(1);
  localparam logic [WORD_W-1:0] OP_LD    = WORD_W'(2);
  localparam logic [WORD_W-1:0] OP_ADD   = WORD_W'(3);
  localparam logic [WORD_W-1:0] OP_MUL   = WORD_W'(4);
  localparam logic [WORD_W-1:0] OP_ST    = WORD_W'(5);
  localparam logic [WORD_W-1:0] OP_JGT   = WORD_W'(6);
  localparam logic [WORD_W-1:0] OP_PRINT = WORD_W'(7);
  localparam logic [WORD_W-1:0] OP_SLEEP = WORD_W'(8);
  localparam logic [WORD_W-1:0] OP_SHELL = WORD_W'(9);

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;     // write load word into memory
    logic start;       // pc from base, leave halt
    logic ignore;      // ignored item result
    logic fetch_arg;   // latch opcode, read operand word
    logic fetch_data;  // latch operand, advance pc, read data word
    logic exec;        // execute latched instruction
    logic publish;     // load output register
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic halted;
  } dp_stat_t;

endpackage

>>> design/acpu_ctrl.sv
// sequencer for the accumulator cpu core: handshakes and instruction phases
module acpu_ctrl
  import acpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_cmd,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_stat_t   stat,
  output dp_ctl_t    ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_OP  = 5'b00010,
    S_RD_ARG = 5'b00100,
    S_RD_DAT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DONE;
          case (in_cmd)
            CMD_LOAD:  ctl.load_wr = 1'b1;
            CMD_START: ctl.start   = 1'b1;
            CMD_STEP: begin
              if (stat.halted) begin
                ctl.ignore = 1'b1;
              end else begin
                state_nxt = S_RD_OP;
              end
            end
            default:   ctl.ignore  = 1'b1;
          endcase
        end
      end
      S_RD_OP: begin
        ctl.fetch_arg = 1'b1;
        state_nxt     = S_RD_ARG;
      end
      S_RD_ARG: begin
        ctl.fetch_data = 1'b1;
        state_nxt      = S_RD_DAT;
      end
      S_RD_DAT: begin
        // data word arrives from memory this cycle, execute on it
        ctl.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          ctl.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/acpu_dp.sv
// datapath of the accumulator cpu core: memory, pc, accumulator, output word
module acpu_dp
  import acpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  output dp_stat_t          stat,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_base,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [31:0]       in_data,
  output logic [2:0]        out_event,
  output logic [31:0]       out_value,
  output logic [31:0]       out_acc,
  output logic [9:0]        out_pc
);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] mem_q;

  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic              halted_r, halted_nxt;
  logic [WORD_W-1:0] op_r, arg_r;
  logic [2:0]        ev_r, ev_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [2:0]        out_event_r;
  logic [31:0]       out_value_r, out_acc_r;
  logic [9:0]        out_pc_r;

  logic [ADDR_W-1:0] rd_addr, wr_addr, daddr;
  logic [WORD_W-1:0] wr_data;
  logic              mem_we;
  logic [WORD_W-1:0] product;

  assign stat.halted = halted_r;
  assign daddr       = arg_r[ADDR_W-1:0] + base_r;
  assign product     = acc_r * mem_q;

  always_comb begin
    rd_addr = pc_r;
    if (ctl.fetch_arg) begin
      rd_addr = pc_r + ADDR_W'(1);
    end else if (ctl.fetch_data) begin
      rd_addr = mem_q[ADDR_W-1:0] + base_r;
    end
  end

  always_comb begin
    mem_we  = ctl.load_wr || (ctl.exec && op_r == OP_ST);
    wr_addr = ctl.load_wr ? in_address : daddr;
    wr_data = ctl.load_wr ? WORD_W'(signed'(in_data)) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    base_nxt   = cfg_we ? cfg_base[ADDR_W-1:0] : base_r;
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    ev_nxt     = ev_r;
    val_nxt    = val_r;
    if (ctl.load_wr) begin
      ev_nxt  = EV_NONE;
      val_nxt = '0;
    end
    if (ctl.start) begin
      pc_nxt     = base_r;
      halted_nxt = 1'b0;
      ev_nxt     = EV_NONE;
      val_nxt    = '0;
    end
    if (ctl.ignore) begin
      ev_nxt  = EV_IGNORED;
      val_nxt = '0;
    end
    if (ctl.fetch_data) begin
      pc_nxt = pc_r + ADDR_W'(2);
    end
    if (ctl.exec) begin
      ev_nxt  = EV_NONE;
      val_nxt = '0;
      case (op_r)
        OP_HALT: begin
          halted_nxt = 1'b1;
          ev_nxt     = EV_HALTED;
        end
        OP_LDI:  acc_nxt = arg_r;
        OP_LD:   acc_nxt = mem_q;
        OP_ADD:  acc_nxt = acc_r + mem_q;
        OP_MUL:  acc_nxt = product;
        OP_JGT: begin
          // taken only for a strictly positive accumulator
          if (acc_r != '0 && !acc_r[WORD_W-1]) begin
            pc_nxt = mem_q[ADDR_W-1:0];
          end
        end
        OP_PRINT: begin
          ev_nxt  = EV_PRINT;
          val_nxt = acc_r;
        end
        OP_SLEEP: begin
          ev_nxt  = EV_SLEEP;
          val_nxt = arg_r;
        end
        OP_SHELL: begin
          ev_nxt  = EV_SHELL;
          val_nxt = arg_r;
        end
        default: ev_nxt = EV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pc_r     <= '0;
      acc_r    <= '0;
      halted_r <= 1'b1;
    end else begin
      base_r   <= base_nxt;
      pc_r     <= pc_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r  <= ev_nxt;
    val_r <= val_nxt;
    if (ctl.fetch_arg) begin
      op_r <= mem_q;
    end
    if (ctl.fetch_data) begin
      arg_r <= mem_q;
    end
    if (ctl.publish) begin
      out_event_r <= ev_r;
      out_value_r <= val_r[31:0];
      out_acc_r   <= acc_r[31:0];
      out_pc_r    <= 10'(pc_r);
    end
  end

  assign out_event = out_event_r;
  assign out_value = out_value_r;
  assign out_acc   = out_acc_r;
  assign out_pc    = out_pc_r;

endmodule

>>> design/accumulator_cpu_core.sv
// accumulator cpu core: a step reads the opcode, operand and data words of the program memory
// in turn and executes on the data word before its result is published; load, start and
// ignored words are published without reads; one word in work at a time; a stalled result
// holds the core in its done phase
// synchronous active-low reset clears pc, accumulator and base, sets halted;
// program memory is not cleared
module accumulator_cpu_core
  import acpu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // address[9:0], data[41:10]
  input  logic [1:0]            in_tuser,   // command[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value[31:0], acc_now[63:32], pc_now[73:64]
  output logic [2:0]            out_tuser,  // event_res[2:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [9:0]            cfg_data    // base_address
);

  dp_ctl_t     ctl;
  dp_stat_t    stat;
  logic [2:0]  ev;
  logic [31:0] value, acc_now;
  logic [9:0]  pc_now;

  assign cfg_ready = 1'b1;

  acpu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  acpu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_base   (cfg_data),
    .in_address (in_tdata[ADDR_W-1:0]),
    .in_data    (in_tdata[41:10]),
    .out_event  (ev),
    .out_value  (value),
    .out_acc    (acc_now),
    .out_pc     (pc_now)
  );

  assign out_tuser = ev;
  assign out_tdata = {6'b0, pc_now, acc_now, value};

endmodule

>>> verif/tb.sv
// testbench for the accumulator cpu core: directed and random programs, shadow cpu check
`timescale 1ns / 1ps

module tb;
  import acpu_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         PHASE_WORDS  = 130;

  localparam logic [WORD_W-1:0] OPCODES [10] = '{OP_HALT, OP_LDI, OP_LD, OP_ADD, OP_MUL,
                                                 OP_ST, OP_JGT, OP_PRINT, OP_SLEEP, OP_SHELL};

  typedef enum int {RX_STREAM, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_pace_t;

  typedef struct packed {
    logic [2:0]        ev;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] acc;
    logic [ADDR_W-1:0] pc;
  } cpu_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // address[9:0], data[41:10]
  logic [1:0]            in_tuser = '0;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // value[31:0], acc_now[63:32], pc_now[73:64]
  logic [2:0]            out_tuser;       // event_res[2:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [9:0]            cfg_data = '0;

  // shadow cpu state
  logic [WORD_W-1:0] mem_image [MEM_DEPTH];
  bit                mem_loaded [MEM_DEPTH];
  logic [ADDR_W-1:0] pc_m = '0;
  logic [WORD_W-1:0] acc_m = '0;
  bit                halted_m = 1'b1;
  logic [ADDR_W-1:0] base_m = '0;

  cpu_result_t pending_results [$];
  int          mismatches = 0;
  int          useful_words = 0;
  int          burst_left = 0;

  bit          hold_req = 1'b0;
  bit          hold_off = 1'b0;
  rx_pace_t    rx_pace = RX_STREAM;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  accumulator_cpu_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // runs one accepted word through the shadow cpu and queues the result it must produce
  function automatic void shadow_execute(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                                         input logic [WORD_W-1:0] word);
    cpu_result_t       r;
    logic [WORD_W-1:0] opcode, operand;
    logic [ADDR_W-1:0] arg_at, data_at;
    r.ev = EV_NONE;
    r.value = '0;
    case (cmd)
      CMD_LOAD: begin
        mem_image[addr] = word;
        mem_loaded[addr] = 1'b1;
      end
      CMD_START: begin
        pc_m = base_m;
        halted_m = 1'b0;
      end
      CMD_STEP: begin
        if (halted_m) begin
          r.ev = EV_IGNORED;
        end else begin
          arg_at = pc_m + 10'd1;
          opcode = mem_image[pc_m];
          operand = mem_image[arg_at];
          data_at = operand[ADDR_W-1:0] + base_m;
          pc_m = pc_m + 10'd2;
          case (opcode)
            OP_HALT: begin
              halted_m = 1'b1;
              r.ev = EV_HALTED;
            end
            OP_LDI: acc_m = operand;
            OP_LD:  acc_m = mem_image[data_at];
            OP_ADD: acc_m = acc_m + mem_image[data_at];
            OP_MUL: acc_m = acc_m * mem_image[data_at];
            OP_ST: begin
              mem_image[data_at] = acc_m;
              mem_loaded[data_at] = 1'b1;
            end
            OP_JGT: begin
              if ($signed(acc_m) > 0) pc_m = mem_image[data_at][ADDR_W-1:0];
            end
            OP_PRINT: begin
              r.ev = EV_PRINT;
              r.value = acc_m;
            end
            OP_SLEEP: begin
              r.ev = EV_SLEEP;
              r.value = operand;
            end
            OP_SHELL: begin
              r.ev = EV_SHELL;
              r.value = operand;
            end
            default: ;
          endcase
        end
      end
      default: r.ev = EV_IGNORED;
    endcase
    r.acc = acc_m;
    r.pc = pc_m;
    pending_results.push_back(r);
    if (r.ev != EV_IGNORED) useful_words++;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] word);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= IN_DATA_W'({word, addr});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow_execute(cmd, addr, word);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [9:0] base);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= base;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_m = base;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one instruction step, or a start or step while halted; code and data it reads are loaded
  // first when missing, and often replaced with fresh random content
  task automatic run_step();
    logic [ADDR_W-1:0] op_at, arg_at, data_at;
    logic [WORD_W-1:0] opcode, operand;
    bit                uses_addr, reads_data;
    int                pick;
    if (halted_m) begin
      if ($urandom_range(0, 3) != 0) send_item(CMD_START, 10'($urandom), $urandom);
      else send_item(CMD_STEP, 10'($urandom), $urandom);
    end else begin
      op_at = pc_m;
      arg_at = pc_m + 10'd1;
      if (!mem_loaded[op_at] || $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 11);
        if (pick < 10) opcode = OPCODES[pick];
        else if (pick == 10) opcode = $urandom;
        else opcode = 32'($urandom_range(10, 15));
        send_item(CMD_LOAD, op_at, opcode);
      end
      opcode = mem_image[op_at];
      uses_addr = opcode inside {OP_LD, OP_ADD, OP_MUL, OP_ST, OP_JGT};
      reads_data = uses_addr && opcode != OP_ST;
      if (!mem_loaded[arg_at] || $urandom_range(0, 2) == 0) begin
        if (uses_addr && $urandom_range(0, 1) == 0) operand = 32'($urandom_range(0, 15));
        else if (uses_addr) operand = $urandom;
        else operand = rand_word();
        send_item(CMD_LOAD, arg_at, operand);
      end
      operand = mem_image[arg_at];
      data_at = operand[ADDR_W-1:0] + base_m;
      // never overwrite the instruction about to execute
      if (reads_data && (!mem_loaded[data_at] ||
          ($urandom_range(0, 3) == 0 && data_at != op_at && data_at != arg_at))) begin
        if (opcode == OP_JGT)
          send_item(CMD_LOAD, data_at,
                    ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1023)));
        else
          send_item(CMD_LOAD, data_at, rand_word());
      end
      send_item(CMD_STEP, 10'($urandom), $urandom);
    end
  endtask

  task automatic test_reset_state();
    send_item(CMD_STEP, 10'h3FF, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 10'h000, 32'h0000_0000);
  endtask

  // base 0 from reset: wrapping multiply, taken jump through a word with high bits set,
  // shell with the most negative operand, then halt and a step while halted
  task automatic test_opcode_chain();
    send_item(CMD_LOAD, 10'd0, OP_LDI);
    send_item(CMD_LOAD, 10'd1, 32'h7FFF_FFFF);
    send_item(CMD_LOAD, 10'd2, OP_MUL);
    send_item(CMD_LOAD, 10'd3, 32'hFFFF_FC01);
    send_item(CMD_LOAD, 10'd4, OP_JGT);
    send_item(CMD_LOAD, 10'd5, 32'd1023);
    send_item(CMD_LOAD, 10'd1023, 32'hFFFF_F806);
    send_item(CMD_LOAD, 10'd6, OP_SHELL);
    send_item(CMD_LOAD, 10'd7, 32'h8000_0000);
    send_item(CMD_LOAD, 10'd8, OP_HALT);
    send_item(CMD_LOAD, 10'd9, 32'd0);
    send_item(CMD_START, 10'h3FF, 32'hFFFF_FFFF);
    repeat (5) send_item(CMD_STEP, 10'($urandom), $urandom);
    send_item(CMD_STEP, 10'($urandom), $urandom);
  endtask

  // base at the top of memory: pc and data addresses wrap, start keeps the accumulator
  task automatic test_base_wrap();
    write_base(10'd1023);
    send_item(CMD_LOAD, 10'd1023, OP_ADD);
    send_item(CMD_LOAD, 10'd0, 32'd2);
    send_item(CMD_LOAD, 10'd1, OP_PRINT);
    send_item(CMD_LOAD, 10'd2, 32'd0);
    send_item(CMD_LOAD, 10'd3, OP_ST);
    send_item(CMD_LOAD, 10'd4, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 10'd5, OP_LD);
    send_item(CMD_LOAD, 10'd6, 32'd1023);
    send_item(CMD_LOAD, 10'd7, OP_SLEEP);
    send_item(CMD_LOAD, 10'd8, 32'h7FFF_FFFF);
    send_item(CMD_LOAD, 10'd9, 32'hDEAD_0001);
    send_item(CMD_LOAD, 10'd10, $urandom);
    send_item(CMD_START, 10'($urandom), $urandom);
    repeat (6) send_item(CMD_STEP, 10'($urandom), $urandom);
  endtask

  task automatic test_output_hold();
    write_base(10'($urandom));
    send_item(CMD_START, 10'($urandom), $urandom);
    hold_req = 1'b1;
    repeat (40) run_step();
    wait_idle();
  endtask

  task automatic test_random_programs();
    int phase_start;
    int r;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) write_base(10'd0);
      else if (phase == 1) write_base(10'd1023);
      else write_base(10'($urandom));
      send_item(CMD_START, 10'($urandom), $urandom);
      phase_start = useful_words;
      while (useful_words - phase_start < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 5) send_item(CMD_LOAD, 10'($urandom), $urandom);
        else if (r < 7) send_item(CMD_START, 10'($urandom), $urandom);
        else if (r < 9) send_item(CMD_UNUSED, 10'($urandom), $urandom);
        else run_step();
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pace = rx_pace_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 96);
    end
    rx_left--;
    rx_phase++;
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_pace)
        RX_STREAM:   out_tready <= 1'b1;
        RX_COIN:     out_tready <= ($urandom_range(0, 1) == 1);
        RX_PERIODIC: out_tready <= (rx_phase % 5 < 2);
        default:     out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // long receiver hold so the core fills up and drops in_tready
  initial begin
    forever begin
      wait (hold_req);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
      hold_req = 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    cpu_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ev = out_tuser;
      got.value = out_tdata[31:0];
      got.acc = out_tdata[63:32];
      got.pc = out_tdata[73:64];
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: event %0d value %h acc %h pc %0d",
                   got.ev, got.value, got.acc, got.pc);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.ev !== want.ev || got.value !== want.value ||
            got.acc !== want.acc || got.pc !== want.pc) begin
          if (mismatches < 10)
            $display("result mismatch: expected event %0d value %h acc %h pc %0d, ",
                     want.ev, want.value, want.acc, want.pc,
                     "got event %0d value %h acc %h pc %0d",
                     got.ev, got.value, got.acc, got.pc);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_opcode_chain();
    test_base_wrap();
    test_output_hold();
    test_random_programs();
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
